// ===== rtl/core/sdt_pkg.sv =====
package sdt_pkg;

  // default window depth, in bytes
  localparam int MAX_DELIM_BYTES_DEF = 8;

  // widths fixed by the register map and payload
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int DELIM_LEN_W = 4;
  localparam int COUNT_W     = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_BYTES = 2'd0,
    CFG_DELIM_LEN   = 2'd1,
    CFG_DROP_EMPTY  = 2'd2
  } cfg_idx_t;

  // one result transaction
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               token_end;
    logic               string_done;
    logic [COUNT_W-1:0] token_count;
  } res_t;

  // per-cycle control from the step logic to the result buffer
  typedef struct packed {
    logic step;
    logic res_valid;
    logic done;
  } step_ctl_t;

endpackage

// ===== rtl/core/sdt_cell.sv =====
module sdt_cell (
  input  logic       clk,
  input  logic       push_en,
  input  logic [7:0] push_byte,
  input  logic       shift_en,
  input  logic [7:0] next_byte,
  input  logic [7:0] delim_byte,
  output logic [7:0] cur_byte,
  output logic       eq
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // window byte as seen after an incoming byte lands here
  assign cur_byte = push_en ? push_byte : byte_r;
  assign eq       = (cur_byte == delim_byte);

  // take the right neighbor's byte when the window drops its oldest byte
  assign byte_nxt = shift_en ? next_byte : cur_byte;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// ===== rtl/core/sdt_result_buf.sv =====
module sdt_result_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  sdt_pkg::step_ctl_t ctl,
  input  sdt_pkg::res_t     res,
  input  logic              out_stall,
  output logic              ready,
  output logic              out_valid,
  output sdt_pkg::res_t     out_res,
  output logic              out_last
);

  logic          pend_valid_r;
  logic          pend_last_r;
  sdt_pkg::res_t pend_res_r;
  logic          out_valid_r;
  logic          out_last_r;
  sdt_pkg::res_t out_res_r;

  logic out_free;
  logic move_step;
  logic move_idle;
  logic move;
  logic move_last;

  // output register can load this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign ready    = !pend_valid_r || out_free;

  // a held result leaves once we know whether it closes its transaction
  assign move_step = ctl.step && pend_valid_r && (pend_last_r || ctl.res_valid || ctl.done);
  assign move_idle = !ctl.step && pend_valid_r && pend_last_r && out_free;
  assign move      = move_step || move_idle;
  assign move_last = pend_last_r || (!ctl.res_valid && ctl.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // holding stage
      if (ctl.step && ctl.res_valid) begin
        pend_valid_r <= 1'b1;
        pend_last_r  <= ctl.done;
      end else if (move) begin
        pend_valid_r <= 1'b0;
      end
      // output stage
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.res_valid) begin
      pend_res_r <= res;
    end
    if (move) begin
      out_res_r  <= pend_res_r;
      out_last_r <= move_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/string_delimiter_splitter.sv =====
// Multi-byte delimiter tokenizer. Takes a string one byte per transaction and splits it at
// each leftmost, non-overlapping occurrence of a 0 to MAX_DELIM_BYTES byte delimiter; content
// bytes come out one per result, a token end is one result, and end of string gives a final
// result with the saturating token count. Steady state is one input byte per cycle while the
// result channel is not stalled, set by the single-step window of compare cells; results are
// registered in a holding stage and an output stage behind the item stage. An end of string
// flushes each byte held in the window, its own byte included, as content, then gives the
// final result. A delimiter match while the window holds more bytes than the delimiter (only
// after the delimiter length was lowered mid-string) drops the delimiter bytes one at a time,
// and bytes drained after such a change leave one at a time. No clearing pass after reset.
module string_delimiter_splitter #(
  parameter int MAX_DELIM_BYTES = sdt_pkg::MAX_DELIM_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           cfg_wr_en,
  input  logic [sdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_byte,
  input  logic                           in_has_byte,
  input  logic                           in_end_of_string,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_token_end,
  output logic                           out_string_done,
  output logic [sdt_pkg::COUNT_W-1:0]    out_token_count,
  output logic                           out_last_result
);

  localparam int FW = $clog2(MAX_DELIM_BYTES + 1);

  // configuration registers
  logic [sdt_pkg::CFG_DATA_W-1:0]  delim_bytes_r;
  logic [sdt_pkg::DELIM_LEN_W-1:0] delim_size_r;
  logic                            drop_empty_r;

  // item stage
  logic       item_valid_r;
  logic       item_pushed_r;
  logic [7:0] item_byte_r;
  logic       item_has_r;
  logic       item_end_r;

  // tokenizer state
  logic [FW-1:0]               fill_r;
  logic [FW-1:0]               fill_nxt;
  logic [FW-1:0]               skip_r;
  logic [FW-1:0]               skip_nxt;
  logic                        nonempty_r;
  logic                        nonempty_nxt;
  logic [sdt_pkg::COUNT_W-1:0] count_r;
  logic [sdt_pkg::COUNT_W-1:0] count_nxt;

  // step logic
  logic                        buf_ready;
  logic                        step_en;
  logic                        push;
  logic [FW-1:0]               fill_a;
  logic [FW-1:0]               eff_len;
  logic                        len_zero;
  logic                        match;
  logic                        drain_pend;
  logic                        drain_after;
  logic                        shift;
  logic                        final_step;
  logic                        kept;
  logic                        done;
  logic [sdt_pkg::COUNT_W-1:0] count_inc;
  sdt_pkg::res_t               res;
  logic                        res_valid;
  sdt_pkg::step_ctl_t          ctl;
  sdt_pkg::res_t               out_res;

  // cell row
  logic [7:0] cell_byte [MAX_DELIM_BYTES];
  logic       cell_eq   [MAX_DELIM_BYTES];
  logic       cell_hit  [MAX_DELIM_BYTES];

  // effective delimiter length, clamped to the window depth
  assign eff_len  = (delim_size_r > sdt_pkg::DELIM_LEN_W'(MAX_DELIM_BYTES)) ?
                    FW'(MAX_DELIM_BYTES) : FW'(delim_size_r);
  assign len_zero = (eff_len == '0);

  assign step_en = item_valid_r && buf_ready;
  assign push    = item_has_r && !item_pushed_r;
  assign fill_a  = fill_r + FW'(push);

  // window of compare cells, oldest byte in cell 0
  for (genvar i = 0; i < MAX_DELIM_BYTES; i++) begin : g_cell
    logic [7:0] right_byte;
    if (i == MAX_DELIM_BYTES - 1) begin : g_tail
      assign right_byte = cell_byte[i];
    end else begin : g_body
      assign right_byte = cell_byte[i+1];
    end

    sdt_cell u_cell (
      .clk        (clk),
      .push_en    (step_en && push && (fill_r == FW'(i))),
      .push_byte  (item_byte_r),
      .shift_en   (step_en && shift),
      .next_byte  (right_byte),
      .delim_byte (delim_bytes_r[8*i +: 8]),
      .cur_byte   (cell_byte[i]),
      .eq         (cell_eq[i])
    );

    assign cell_hit[i] = cell_eq[i] || (FW'(i) >= eff_len);
  end

  // delimiter matches over its length
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
      match = match && cell_hit[i];
    end
  end

  assign drain_pend = item_has_r && (len_zero ? (fill_a != '0) : (fill_a >= eff_len));
  assign kept       = !drop_empty_r || nonempty_r;
  assign count_inc  = (count_r == sdt_pkg::COUNT_MAX) ? count_r :
                      count_r + sdt_pkg::COUNT_W'(1);

  // one window action per cycle, applied when the step is enabled
  always_comb begin
    shift        = 1'b0;
    fill_nxt     = fill_a;
    skip_nxt     = skip_r;
    nonempty_nxt = nonempty_r;
    count_nxt    = count_r;
    res          = '0;
    res_valid    = 1'b0;
    final_step   = 1'b0;
    if (skip_r != '0) begin
      // finish dropping a matched delimiter
      shift    = 1'b1;
      fill_nxt = fill_a - FW'(1);
      skip_nxt = skip_r - FW'(1);
    end else if (drain_pend) begin
      if (len_zero || !match) begin
        shift          = 1'b1;
        fill_nxt       = fill_a - FW'(1);
        nonempty_nxt   = 1'b1;
        res.out_byte   = cell_byte[0];
        res.byte_valid = 1'b1;
        res_valid      = 1'b1;
      end else begin
        nonempty_nxt  = 1'b0;
        res.token_end = 1'b1;
        res_valid     = kept;
        if (kept) begin
          count_nxt = count_inc;
        end
        if (fill_a == eff_len) begin
          fill_nxt = '0;
        end else begin
          shift    = 1'b1;
          fill_nxt = fill_a - FW'(1);
          skip_nxt = eff_len - FW'(1);
        end
      end
    end else if (item_end_r) begin
      if (fill_a != '0) begin
        // flush held bytes as content
        shift          = 1'b1;
        fill_nxt       = fill_a - FW'(1);
        nonempty_nxt   = 1'b1;
        res.out_byte   = cell_byte[0];
        res.byte_valid = 1'b1;
        res_valid      = 1'b1;
      end else begin
        // close the string
        res.token_end   = kept;
        res.string_done = 1'b1;
        res.token_count = kept ? count_inc : count_r;
        res_valid       = 1'b1;
        final_step      = 1'b1;
        fill_nxt        = '0;
        nonempty_nxt    = 1'b0;
        count_nxt       = '0;
      end
    end
  end

  // transaction is finished once nothing is left to drain or flush
  assign drain_after = item_has_r && (len_zero ? (fill_nxt != '0) : (fill_nxt >= eff_len));
  assign done        = (skip_nxt == '0) && !drain_after && (!item_end_r || final_step);

  assign in_stall = item_valid_r && !(step_en && done);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= '0;
      delim_size_r  <= sdt_pkg::DELIM_LEN_W'(1);
      drop_empty_r  <= 1'b0;
      item_valid_r  <= 1'b0;
      item_pushed_r <= 1'b0;
      fill_r        <= '0;
      skip_r        <= '0;
      nonempty_r    <= 1'b0;
      count_r       <= '0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (sdt_pkg::cfg_idx_t'(cfg_index))
          sdt_pkg::CFG_DELIM_BYTES: delim_bytes_r <= cfg_data;
          sdt_pkg::CFG_DELIM_LEN:   delim_size_r  <= cfg_data[sdt_pkg::DELIM_LEN_W-1:0];
          sdt_pkg::CFG_DROP_EMPTY:  drop_empty_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      // tokenizer state
      if (step_en) begin
        fill_r     <= fill_nxt;
        skip_r     <= skip_nxt;
        nonempty_r <= nonempty_nxt;
        count_r    <= count_nxt;
      end
      // item stage
      if (in_valid && !in_stall) begin
        item_valid_r  <= 1'b1;
        item_pushed_r <= 1'b0;
      end else if (step_en && done) begin
        item_valid_r <= 1'b0;
      end else if (step_en) begin
        item_pushed_r <= 1'b1;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_byte_r <= in_char_byte;
      item_has_r  <= in_has_byte;
      item_end_r  <= in_end_of_string;
    end
  end

  assign ctl.step      = step_en;
  assign ctl.res_valid = res_valid;
  assign ctl.done      = done;

  sdt_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .out_stall (out_stall),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last_result)
  );

  assign out_byte        = out_res.out_byte;
  assign out_byte_valid  = out_res.byte_valid;
  assign out_token_end   = out_res.token_end;
  assign out_string_done = out_res.string_done;
  assign out_token_count = out_res.token_count;

  // window never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_DELIM_BYTES))
    else $error("window fill beyond depth");

  // a delimiter drop in progress belongs to a held transaction
  a_skip_item: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) |-> item_valid_r)
    else $error("delimiter drop without transaction");

  // the final result of a string always closes its transaction
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_done) |-> out_last_result)
    else $error("string done without last result");

  // count is only reported with the final result
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_string_done) |-> (out_token_count == '0))
    else $error("token count outside final result");

  // after a string closes the tokenizer state is back at rest
  a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && final_step) |=> (fill_r == '0 && count_r == '0 && !nonempty_r))
    else $error("state not cleared at end of string");

endmodule

// ===== test/string_delimiter_splitter_tb.sv =====
`timescale 1ns / 1ps

module string_delimiter_splitter_tb;

  localparam int          WIN_DEPTH     = sdt_pkg::MAX_DELIM_BYTES_DEF;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          QUIET_LIMIT   = 1000;
  localparam int          TOTAL_ITEMS   = 160;
  localparam logic [63:0] FULL_DELIM    = 64'hFF00_8001_7F55_AA00;
  localparam logic [63:0] XYZW_DELIM    = 64'h0000_0000_777A_7978;

  // one input transaction waiting to be sent
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eos;
  } char_item_t;

  // one expected result transaction
  typedef struct packed {
    logic [7:0]  data;
    logic        data_ok;
    logic        tok_end;
    logic        str_done;
    logic [15:0] count;
    logic        last;
  } piece_t;

  logic                           clk;
  logic                           rst_n            = 1'b0;
  logic                           cfg_wr_en        = 1'b0;
  logic [sdt_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [sdt_pkg::CFG_DATA_W-1:0] cfg_data         = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_char_byte     = 8'h00;
  logic                           in_has_byte      = 1'b0;
  logic                           in_end_of_string = 1'b0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_byte_valid;
  logic                           out_token_end;
  logic                           out_string_done;
  logic [sdt_pkg::COUNT_W-1:0]    out_token_count;
  logic                           out_last_result;

  // pending input and expected output
  char_item_t char_q[$];
  piece_t     piece_q[$];

  // shadow of the configuration registers, reset values
  logic [63:0] delim_pat    = 64'd0;
  logic [3:0]  delim_size   = 4'd1;
  logic        drop_empties = 1'b0;

  // tokenizer state as predicted
  logic [7:0]  win[WIN_DEPTH];
  int          win_fill     = 0;
  logic        cur_nonempty = 1'b0;
  logic [15:0] tok_total    = 16'd0;

  int         n_errors     = 0;
  int         n_items      = 0;
  int         gap_left     = 0;
  int         stall_left   = 0;
  int         quiet_cycles = 0;
  bit         no_idle      = 1'b0;
  char_item_t nxt;
  piece_t     want;

  string_delimiter_splitter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_has_byte      (in_has_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_token_end    (out_token_end),
    .out_string_done  (out_string_done),
    .out_token_count  (out_token_count),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic void add_piece(logic [7:0] d, logic dv, logic te, logic sd,
                                    logic [15:0] cnt);
    piece_t p;
    p.data     = d;
    p.data_ok  = dv;
    p.tok_end  = te;
    p.str_done = sd;
    p.count    = cnt;
    p.last     = 1'b0;
    piece_q.push_back(p);
  endfunction

  function automatic void shift_window(int k);
    for (int i = 0; i + k < win_fill; i++) win[i] = win[i + k];
    win_fill -= k;
  endfunction

  // oldest pending byte leaves as token content
  function automatic void pass_oldest();
    add_piece(win[0], 1'b1, 1'b0, 1'b0, 16'd0);
    cur_nonempty = 1'b1;
    shift_window(1);
  endfunction

  // close the current token, tell whether it counts
  function automatic logic close_token();
    logic kept;
    kept = !drop_empties || cur_nonempty;
    if (kept && tok_total != 16'hFFFF) tok_total++;
    cur_nonempty = 1'b0;
    return kept;
  endfunction

  // expected results of one accepted input transaction
  function automatic void split_step(logic [7:0] ch, logic has, logic eos);
    int     first;
    int     len;
    logic   hit;
    logic   kept;
    piece_t p;
    first = piece_q.size();
    len = (delim_size > WIN_DEPTH) ? WIN_DEPTH : delim_size;
    if (has) begin
      if (win_fill >= WIN_DEPTH) pass_oldest();
      win[win_fill] = ch;
      win_fill++;
      if (len == 0) begin
        while (win_fill > 0) pass_oldest();
      end else begin
        while (win_fill >= len) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++)
            if (win[i] != delim_pat[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            shift_window(len);
            if (close_token()) add_piece(8'h00, 1'b0, 1'b1, 1'b0, 16'd0);
          end else begin
            pass_oldest();
          end
        end
      end
    end
    if (eos) begin
      while (win_fill > 0) pass_oldest();
      kept = close_token();
      add_piece(8'h00, 1'b0, kept, 1'b1, tok_total);
      win_fill     = 0;
      cur_nonempty = 1'b0;
      tok_total    = 16'd0;
    end
    if (piece_q.size() > first) begin
      p = piece_q.pop_back();
      p.last = 1'b1;
      piece_q.push_back(p);
    end
  endfunction

  function automatic void queue_char(logic [7:0] ch, logic has, logic eos);
    char_item_t it;
    it.ch  = ch;
    it.has = has;
    it.eos = eos;
    char_q.push_back(it);
    n_items++;
  endfunction

  // string built from delimiter copies, delimiter prefixes, letters and noise
  function automatic void queue_random_string(int n_parts, bit close);
    int len;
    int r;
    int cut;
    len = (delim_size > WIN_DEPTH) ? WIN_DEPTH : delim_size;
    for (int k = 0; k < n_parts; k++) begin
      r = $urandom_range(0, 99);
      if (len > 0 && r < 30) begin
        for (int j = 0; j < len; j++) queue_char(delim_pat[8*j +: 8], 1'b1, 1'b0);
      end else if (len > 1 && r < 42) begin
        cut = $urandom_range(1, len - 1);
        for (int j = 0; j < cut; j++) queue_char(delim_pat[8*j +: 8], 1'b1, 1'b0);
      end else if (r < 50) begin
        queue_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (r < 60) begin
        queue_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
        queue_char(pick_letter(), 1'b1, 1'b0);
      end
    end
    if (close) begin
      if ($urandom_range(0, 2) == 0) queue_char(pick_letter(), 1'b1, 1'b1);
      else queue_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endfunction

  // block idle: nothing queued, nothing in flight, then let it settle
  task automatic wait_idle();
    do @(negedge clk);
    while (char_q.size() != 0 || in_valid || piece_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(sdt_pkg::cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sdt_pkg::CFG_DELIM_BYTES: delim_pat    = val;
      sdt_pkg::CFG_DELIM_LEN:   delim_size   = val[3:0];
      sdt_pkg::CFG_DROP_EMPTY:  drop_empties = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] pat, logic [3:0] len, logic drop);
    wait_idle();
    cfg_write(sdt_pkg::CFG_DELIM_BYTES, pat);
    cfg_write(sdt_pkg::CFG_DELIM_LEN, {60'd0, len});
    cfg_write(sdt_pkg::CFG_DROP_EMPTY, {63'd0, drop});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [63:0] pat;
    logic [3:0]  len;
    int          r;
    int          n_str;
    int          n_parts;
    bit          close;
    bit          str_open;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero byte splits, idle transaction, byte with end, empty string
    queue_char(8'h5A, 1'b0, 1'b0);
    queue_char(8'h61, 1'b1, 1'b0);
    queue_char(8'h00, 1'b1, 1'b0);
    queue_char(8'hFF, 1'b1, 1'b0);
    queue_char(8'h00, 1'b1, 1'b1);
    queue_char(8'hA5, 1'b0, 1'b1);

    // oversized length clamps to the full window
    set_config(FULL_DELIM, 4'd15, 1'b0);
    for (int i = 0; i < WIN_DEPTH; i++)
      queue_char(FULL_DELIM[8*i +: 8], 1'b1, i == WIN_DEPTH - 1);

    // empty delimiter never splits; the empty token of an empty string is dropped
    set_config('1, 4'd0, 1'b1);
    queue_char(8'hFF, 1'b1, 1'b1);
    queue_char(8'h00, 1'b0, 1'b1);

    // back-to-back delimiters give dropped empty tokens
    set_config(64'h2C2C, 4'd2, 1'b1);
    repeat (4) queue_char(8'h2C, 1'b1, 1'b0);
    queue_char(8'h78, 1'b1, 1'b0);
    queue_char(8'h00, 1'b0, 1'b1);

    // shorter delimiter set while the window holds bytes
    set_config(XYZW_DELIM, 4'd4, 1'b0);
    queue_char(8'h78, 1'b1, 1'b0);
    queue_char(8'h79, 1'b1, 1'b0);
    queue_char(8'h7A, 1'b1, 1'b0);
    set_config(XYZW_DELIM, 4'd2, 1'b0);
    queue_char(8'h71, 1'b1, 1'b1);

    // random settings and strings, a string may stay open across a setting change
    str_open = 1'b0;
    while (n_items < TOTAL_ITEMS) begin
      for (int i = 0; i < 8; i++)
        pat[8*i +: 8] = ($urandom_range(0, 9) < 6) ? pick_letter() :
                        8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      case (r)
        0:       len = 4'd0;
        1:       len = 4'd8;
        2:       len = 4'($urandom_range(9, 15));
        default: len = 4'($urandom_range(1, 4));
      endcase
      set_config(pat, len, 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      n_str = $urandom_range(1, 3);
      for (int s = 0; s < n_str; s++) begin
        n_parts = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        close = !(s == n_str - 1 && $urandom_range(0, 3) == 0);
        queue_random_string(n_parts, close);
        str_open = !close;
      end
    end
    if (str_open) queue_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);

    wait_idle();
    if (n_errors == 0) $display("string_delimiter_splitter_tb OK");
    else $display("string_delimiter_splitter_tb NOT OK");
    $finish;
  end

  // input driver, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) split_step(in_char_byte, in_has_byte, in_end_of_string);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          nxt = char_q.pop_front();
          in_char_byte     <= nxt.ch;
          in_has_byte      <= nxt.has;
          in_end_of_string <= nxt.eos;
          in_valid         <= 1'b1;
          gap_left = (no_idle || $urandom_range(0, 99) < 55) ? 0 : pause_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (piece_q.size() == 0) begin
          $error("result with nothing expected: out_byte %02h byte_valid %0b token_end %0b",
                 out_byte, out_byte_valid, out_token_end);
          n_errors++;
        end else begin
          want = piece_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            n_errors++;
          end
          if (out_byte_valid !== want.data_ok) begin
            $error("byte_valid: expected %0b, got %0b", want.data_ok, out_byte_valid);
            n_errors++;
          end
          if (out_token_end !== want.tok_end) begin
            $error("token_end: expected %0b, got %0b", want.tok_end, out_token_end);
            n_errors++;
          end
          if (out_string_done !== want.str_done) begin
            $error("string_done: expected %0b, got %0b", want.str_done, out_string_done);
            n_errors++;
          end
          if (out_token_count !== want.count) begin
            $error("token_count: expected %0d, got %0d", want.count, out_token_count);
            n_errors++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, out_last_result);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!no_idle && $urandom_range(0, 99) < 20) stall_left = pause_len();
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("string_delimiter_splitter_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
